@@ design/sliding_mode_emf_observer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Sliding-mode EMF observer assertion macros
// Shorthand for the concurrent checks, clocked on clock and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MODE_EMF_OBSERVER_TOP_DEFINES_SVH
`define SLIDING_MODE_EMF_OBSERVER_TOP_DEFINES_SVH

// Same-cycle implication or invariant
`define SMO_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition now, consequence in the next cycle
`define SMO_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ design/smo_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding-mode EMF observer package
// Word formats, ALU operation codes and the micro-program of the sequencer.
// ----------------------------------------------------------------------------
package smo_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_W    = 16;
   localparam int SW_W      = FRAC_W + 2;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 5 * DATA_W;
   localparam int RSP_RAW_W = 4 * DATA_W + 2 * SW_W;
   localparam int RSP_W     = ((RSP_RAW_W + 7) / 8) * 8;
   localparam int PROG_LEN  = 30;
   localparam int PC_W      = $clog2(PROG_LEN);

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [SW_W-1:0]   sw_type;
   typedef logic [DATA_W-2:0]        uword_type;

   localparam sw_type    SW_ONE       = sw_type'(1 << FRAC_W);
   localparam sw_type    SW_MINUS_ONE = -SW_ONE;
   localparam uword_type BL_RESET     = uword_type'(1 << FRAC_W);

   localparam logic [PC_W-1:0] PC_ERR_LAST  = PC_W'(1);
   localparam logic [PC_W-1:0] PC_PROG_LAST = PC_W'(PROG_LEN - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_A         = 3'd0,
      REG_GAIN_B         = 3'd1,
      REG_GAIN_C         = 3'd2,
      REG_SWITCH_GAIN    = 3'd3,
      REG_EMF_GAIN       = 3'd4,
      REG_BOUNDARY_LAYER = 3'd5,
      REG_SAMPLE_PERIOD  = 3'd6
   } csr_idx_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL
   } alu_op_type;

   typedef enum logic [4:0] {
      SRC_GA, SRC_GB, SRC_GC, SRC_GK, SRC_GM, SRC_TS,
      SRC_IA, SRC_IB, SRC_VA, SRC_VB, SRC_W,
      SRC_PIA, SRC_PIB, SRC_PEA, SRC_PEB,
      SRC_ZA, SRC_ZB, SRC_BW, SRC_CK, SRC_CM, SRC_TW,
      SRC_T1, SRC_T2, SRC_NIA, SRC_NIB, SRC_NEA, SRC_NEB
   } src_type;

   typedef enum logic [3:0] {
      DST_EA, DST_EB, DST_BW, DST_CK, DST_CM, DST_TW,
      DST_T1, DST_T2, DST_NIA, DST_NIB, DST_NEA, DST_NEB
   } dst_type;

   typedef struct packed {
      alu_op_type op;
      src_type    src_a;
      src_type    src_b;
      dst_type    dst;
   } uop_type;

   // Switching value returned by the divider
   typedef struct packed {
      logic   done;
      sw_type value;
   } sw_result_type;

   // Observer update, one ALU operation per step; steps 0 and 1 form the errors
   function automatic uop_type prog_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         5'd0:    u = '{ALU_SUB, SRC_PIA, SRC_IA,  DST_EA};
         5'd1:    u = '{ALU_SUB, SRC_PIB, SRC_IB,  DST_EB};
         5'd2:    u = '{ALU_MUL, SRC_GB,  SRC_W,   DST_BW};
         5'd3:    u = '{ALU_MUL, SRC_GC,  SRC_GK,  DST_CK};
         5'd4:    u = '{ALU_MUL, SRC_GC,  SRC_GM,  DST_CM};
         5'd5:    u = '{ALU_MUL, SRC_TS,  SRC_W,   DST_TW};
         5'd6:    u = '{ALU_MUL, SRC_GA,  SRC_PIA, DST_T1};
         5'd7:    u = '{ALU_MUL, SRC_BW,  SRC_PIB, DST_T2};
         5'd8:    u = '{ALU_SUB, SRC_T1,  SRC_T2,  DST_NIA};
         5'd9:    u = '{ALU_SUB, SRC_VA,  SRC_PEA, DST_T1};
         5'd10:   u = '{ALU_MUL, SRC_GC,  SRC_T1,  DST_T1};
         5'd11:   u = '{ALU_ADD, SRC_NIA, SRC_T1,  DST_NIA};
         5'd12:   u = '{ALU_MUL, SRC_CK,  SRC_ZA,  DST_T1};
         5'd13:   u = '{ALU_SUB, SRC_NIA, SRC_T1,  DST_NIA};
         5'd14:   u = '{ALU_MUL, SRC_GA,  SRC_PIB, DST_T1};
         5'd15:   u = '{ALU_MUL, SRC_BW,  SRC_PIA, DST_T2};
         5'd16:   u = '{ALU_ADD, SRC_T1,  SRC_T2,  DST_NIB};
         5'd17:   u = '{ALU_SUB, SRC_VB,  SRC_PEB, DST_T1};
         5'd18:   u = '{ALU_MUL, SRC_GC,  SRC_T1,  DST_T1};
         5'd19:   u = '{ALU_ADD, SRC_NIB, SRC_T1,  DST_NIB};
         5'd20:   u = '{ALU_MUL, SRC_CK,  SRC_ZB,  DST_T1};
         5'd21:   u = '{ALU_SUB, SRC_NIB, SRC_T1,  DST_NIB};
         5'd22:   u = '{ALU_MUL, SRC_TW,  SRC_PEB, DST_T1};
         5'd23:   u = '{ALU_SUB, SRC_PEA, SRC_T1,  DST_NEA};
         5'd24:   u = '{ALU_MUL, SRC_CM,  SRC_ZA,  DST_T1};
         5'd25:   u = '{ALU_ADD, SRC_NEA, SRC_T1,  DST_NEA};
         5'd26:   u = '{ALU_MUL, SRC_TW,  SRC_PEA, DST_T1};
         5'd27:   u = '{ALU_ADD, SRC_PEB, SRC_T1,  DST_NEB};
         5'd28:   u = '{ALU_MUL, SRC_CM,  SRC_ZB,  DST_T1};
         5'd29:   u = '{ALU_ADD, SRC_NEB, SRC_T1,  DST_NEB};
         default: u = '{ALU_ADD, SRC_T1,  SRC_T1,  DST_T1};
      endcase
      return u;
   endfunction

endpackage

@@ design/smo_alu.sv @@
// ----------------------------------------------------------------------------
// Shared saturating ALU
// Q multiply with floor shift, or add/subtract, saturated to one data word.
// ----------------------------------------------------------------------------
module smo_alu (
   input  smo_pkg::alu_op_type op,
   input  smo_pkg::word_type   a,
   input  smo_pkg::word_type   b,
   output smo_pkg::word_type   y
);
   import smo_pkg::*;

   localparam word_type WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic signed [2*DATA_W-1:0] prod;
   logic signed [2*DATA_W-1:0] prod_sh;
   logic signed [DATA_W:0]     sum;
   logic                       prod_fits;

   always_comb begin
      prod    = a * b;
      // arithmetic shift gives the floor of the scaled product
      prod_sh = prod >>> FRAC_W;
      prod_fits = (prod_sh[2*DATA_W-1:DATA_W-1] == '0)
               || (prod_sh[2*DATA_W-1:DATA_W-1] == '1);
      if (op == ALU_SUB) begin
         sum = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      end else begin
         sum = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      end
      case (op)
         ALU_MUL: begin
            if (prod_fits) begin
               y = prod_sh[DATA_W-1:0];
            end else if (prod_sh[2*DATA_W-1]) begin
               y = WORD_MIN;
            end else begin
               y = WORD_MAX;
            end
         end
         default: begin
            if (sum[DATA_W] == sum[DATA_W-1]) begin
               y = sum[DATA_W-1:0];
            end else if (sum[DATA_W]) begin
               y = WORD_MIN;
            end else begin
               y = WORD_MAX;
            end
         end
      endcase
   end

endmodule

@@ design/smo_switch.sv @@
// ----------------------------------------------------------------------------
// Switching value divider
// Saturates a current error against the boundary layer; inside the layer,
// restoring division yields error / boundary, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module smo_switch (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  smo_pkg::word_type          err,
   input  smo_pkg::uword_type         bound,
   output smo_pkg::sw_result_type     result
);
   import smo_pkg::*;

   localparam int CNT_W = $clog2(FRAC_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_W);

   logic signed [DATA_W:0] err_x;
   logic signed [DATA_W:0] bnd_x;
   logic                   above;
   logic                   below;
   logic [DATA_W-1:0]      err_u;
   logic [DATA_W-1:0]      err_mag;
   logic [DATA_W-1:0]      bnd_u;
   logic [DATA_W-1:0]      rem_sh;
   logic                   ge;
   logic [DATA_W-1:0]      rem_in;
   logic [FRAC_W:0]        quot_in;
   sw_type                 quot_s;

   logic [DATA_W-1:0]      rem_ff;
   logic [FRAC_W:0]        quot_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   neg_ff;
   logic                   busy_ff;
   logic                   done_ff;
   sw_type                 z_ff;

   always_comb begin
      err_x   = {err[DATA_W-1], err};
      bnd_x   = {2'b00, bound};
      above   = err_x > bnd_x;
      below   = err_x < -bnd_x;
      err_u   = err;
      err_mag = err_u[DATA_W-1] ? (~err_u + 1'b1) : err_u;
      bnd_u   = {1'b0, bound};
      // the integer bit comes first, without a shift
      rem_sh  = (cnt_ff == '0) ? rem_ff : {rem_ff[DATA_W-2:0], 1'b0};
      ge      = rem_sh >= bnd_u;
      rem_in  = ge ? (rem_sh - bnd_u) : rem_sh;
      quot_in = {quot_ff[FRAC_W-1:0], ge};
      quot_s  = {1'b0, quot_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= '0;
            if (above || below || (err == '0)) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= err[DATA_W-1];
         rem_ff  <= err_mag;
         quot_ff <= '0;
         if (above) begin
            z_ff <= SW_ONE;
         end else if (below) begin
            z_ff <= SW_MINUS_ONE;
         end else begin
            z_ff <= '0;
         end
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         if (cnt_ff == LAST_STEP) begin
            z_ff <= neg_ff ? -quot_s : quot_s;
         end
      end
   end

   assign result.done  = done_ff;
   assign result.value = z_ff;

endmodule

@@ design/sliding_mode_emf_observer_top.sv @@
// ----------------------------------------------------------------------------
// Sliding-mode back-EMF observer, top level
// One observer update per request transaction, run by a small sequencer.
// ----------------------------------------------------------------------------
// A request carries measured alpha/beta currents, alpha/beta voltages and the
// electrical speed; the response carries the new current and back-EMF
// estimates and both switching values: estimates in Q16.16 and switching values
// in Q2.16, all signed with saturation. A transaction is shorter when a current
// error lies outside the boundary layer: two error subtractions and 28 update
// steps share one multiply/add unit, one step a cycle, and each switching value
// goes through a restoring divider at one quotient bit a cycle (17 bits).
// req_tready is high only while the block is idle; a finished response waits in
// its output register. The user must write registers through the csr_ port only
// while no transaction is in progress; the block does not enforce this.
`include "sliding_mode_emf_observer_top_defines.svh"

module sliding_mode_emf_observer_top (
   input  logic                              clock,
   input  logic                              reset,
   // current_alpha, current_beta, voltage_alpha, voltage_beta, electrical_speed
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [smo_pkg::REQ_W-1:0]         req_tdata,
   // est_current_alpha, est_current_beta, est_emf_alpha, est_emf_beta,
   // switch_alpha, switch_beta, zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [smo_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                              csr_we,
   input  logic [smo_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smo_pkg::DATA_W-1:0]        csr_wdata
);
   import smo_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALU,
      S_DIV_GO,
      S_DIV_WAIT,
      S_OUT
   } state_type;

   state_type         state_ff;
   logic [PC_W-1:0]   pc_ff;
   logic              div_sel_ff;
   logic              rsp_valid_ff;

   word_type  ga_ff, gb_ff, gc_ff, gk_ff, gm_ff;
   uword_type bl_ff, ts_ff;
   word_type  ia_ff, ib_ff, va_ff, vb_ff, w_ff;
   word_type  prev_ia_ff, prev_ib_ff, prev_ea_ff, prev_eb_ff;
   word_type  ea_ff, eb_ff, bw_ff, ck_ff, cm_ff, tw_ff, t1_ff, t2_ff;
   word_type  nia_ff, nib_ff, nea_ff, neb_ff;
   sw_type    za_ff, zb_ff;
   sw_type    sw_a_ff, sw_b_ff;

   uop_type       uop;
   word_type      op_a;
   word_type      op_b;
   word_type      alu_y;
   word_type      za_w;
   word_type      zb_w;
   logic          req_accept;
   logic          rsp_load;
   logic          div_start;
   word_type      div_err;
   sw_result_type div_res;

   assign uop        = prog_rom(pc_ff);
   assign za_w       = {{(DATA_W-SW_W){za_ff[SW_W-1]}}, za_ff};
   assign zb_w       = {{(DATA_W-SW_W){zb_ff[SW_W-1]}}, zb_ff};
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign div_start  = (state_ff == S_DIV_GO);
   assign div_err    = div_sel_ff ? eb_ff : ea_ff;

   always_comb begin
      case (uop.src_a)
         SRC_GA:  op_a = ga_ff;
         SRC_GB:  op_a = gb_ff;
         SRC_GC:  op_a = gc_ff;
         SRC_GK:  op_a = gk_ff;
         SRC_GM:  op_a = gm_ff;
         SRC_TS:  op_a = {1'b0, ts_ff};
         SRC_IA:  op_a = ia_ff;
         SRC_IB:  op_a = ib_ff;
         SRC_VA:  op_a = va_ff;
         SRC_VB:  op_a = vb_ff;
         SRC_W:   op_a = w_ff;
         SRC_PIA: op_a = prev_ia_ff;
         SRC_PIB: op_a = prev_ib_ff;
         SRC_PEA: op_a = prev_ea_ff;
         SRC_PEB: op_a = prev_eb_ff;
         SRC_ZA:  op_a = za_w;
         SRC_ZB:  op_a = zb_w;
         SRC_BW:  op_a = bw_ff;
         SRC_CK:  op_a = ck_ff;
         SRC_CM:  op_a = cm_ff;
         SRC_TW:  op_a = tw_ff;
         SRC_T1:  op_a = t1_ff;
         SRC_T2:  op_a = t2_ff;
         SRC_NIA: op_a = nia_ff;
         SRC_NIB: op_a = nib_ff;
         SRC_NEA: op_a = nea_ff;
         SRC_NEB: op_a = neb_ff;
         default: op_a = '0;
      endcase
      case (uop.src_b)
         SRC_GA:  op_b = ga_ff;
         SRC_GB:  op_b = gb_ff;
         SRC_GC:  op_b = gc_ff;
         SRC_GK:  op_b = gk_ff;
         SRC_GM:  op_b = gm_ff;
         SRC_TS:  op_b = {1'b0, ts_ff};
         SRC_IA:  op_b = ia_ff;
         SRC_IB:  op_b = ib_ff;
         SRC_VA:  op_b = va_ff;
         SRC_VB:  op_b = vb_ff;
         SRC_W:   op_b = w_ff;
         SRC_PIA: op_b = prev_ia_ff;
         SRC_PIB: op_b = prev_ib_ff;
         SRC_PEA: op_b = prev_ea_ff;
         SRC_PEB: op_b = prev_eb_ff;
         SRC_ZA:  op_b = za_w;
         SRC_ZB:  op_b = zb_w;
         SRC_BW:  op_b = bw_ff;
         SRC_CK:  op_b = ck_ff;
         SRC_CM:  op_b = cm_ff;
         SRC_TW:  op_b = tw_ff;
         SRC_T1:  op_b = t1_ff;
         SRC_T2:  op_b = t2_ff;
         SRC_NIA: op_b = nia_ff;
         SRC_NIB: op_b = nib_ff;
         SRC_NEA: op_b = nea_ff;
         SRC_NEB: op_b = neb_ff;
         default: op_b = '0;
      endcase
   end

   smo_alu u_alu (
      .op (uop.op),
      .a  (op_a),
      .b  (op_b),
      .y  (alu_y)
   );

   smo_switch u_switch (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .err    (div_err),
      .bound  (bl_ff),
      .result (div_res)
   );

   // Sequencer and response handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         div_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  pc_ff    <= '0;
                  state_ff <= S_ALU;
               end
            end
            S_ALU: begin
               pc_ff <= pc_ff + 1'b1;
               if (pc_ff == PC_ERR_LAST) begin
                  div_sel_ff <= 1'b0;
                  state_ff   <= S_DIV_GO;
               end else if (pc_ff == PC_PROG_LAST) begin
                  state_ff <= S_OUT;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_res.done) begin
                  if (!div_sel_ff) begin
                     div_sel_ff <= 1'b1;
                     state_ff   <= S_DIV_GO;
                  end else begin
                     state_ff <= S_ALU;
                  end
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Configuration registers and observer state
   always_ff @(posedge clock) begin
      if (reset) begin
         ga_ff      <= '0;
         gb_ff      <= '0;
         gc_ff      <= '0;
         gk_ff      <= '0;
         gm_ff      <= '0;
         bl_ff      <= BL_RESET;
         ts_ff      <= '0;
         prev_ia_ff <= '0;
         prev_ib_ff <= '0;
         prev_ea_ff <= '0;
         prev_eb_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_GAIN_A:         ga_ff <= csr_wdata;
               REG_GAIN_B:         gb_ff <= csr_wdata;
               REG_GAIN_C:         gc_ff <= csr_wdata;
               REG_SWITCH_GAIN:    gk_ff <= csr_wdata;
               REG_EMF_GAIN:       gm_ff <= csr_wdata;
               REG_BOUNDARY_LAYER: bl_ff <= csr_wdata[DATA_W-2:0];
               REG_SAMPLE_PERIOD:  ts_ff <= csr_wdata[DATA_W-2:0];
               default: ;
            endcase
         end
         // commit the new estimates as the response goes out
         if (rsp_load) begin
            prev_ia_ff <= nia_ff;
            prev_ib_ff <= nib_ff;
            prev_ea_ff <= nea_ff;
            prev_eb_ff <= neb_ff;
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         ia_ff <= req_tdata[DATA_W-1:0];
         ib_ff <= req_tdata[2*DATA_W-1:DATA_W];
         va_ff <= req_tdata[3*DATA_W-1:2*DATA_W];
         vb_ff <= req_tdata[4*DATA_W-1:3*DATA_W];
         w_ff  <= req_tdata[5*DATA_W-1:4*DATA_W];
      end
      if (state_ff == S_ALU) begin
         case (uop.dst)
            DST_EA:  ea_ff  <= alu_y;
            DST_EB:  eb_ff  <= alu_y;
            DST_BW:  bw_ff  <= alu_y;
            DST_CK:  ck_ff  <= alu_y;
            DST_CM:  cm_ff  <= alu_y;
            DST_TW:  tw_ff  <= alu_y;
            DST_T1:  t1_ff  <= alu_y;
            DST_T2:  t2_ff  <= alu_y;
            DST_NIA: nia_ff <= alu_y;
            DST_NIB: nib_ff <= alu_y;
            DST_NEA: nea_ff <= alu_y;
            DST_NEB: neb_ff <= alu_y;
            default: ;
         endcase
      end
      if ((state_ff == S_DIV_WAIT) && div_res.done) begin
         if (div_sel_ff) begin
            zb_ff <= div_res.value;
         end else begin
            za_ff <= div_res.value;
         end
      end
      if (rsp_load) begin
         sw_a_ff <= za_ff;
         sw_b_ff <= zb_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-RSP_RAW_W){1'b0}}, sw_b_ff, sw_a_ff,
                        prev_eb_ff, prev_ea_ff, prev_ib_ff, prev_ia_ff};

   `SMO_ASSERT(a_sw_range, rsp_tvalid |-> (sw_a_ff <= SW_ONE && sw_a_ff >= SW_MINUS_ONE && sw_b_ff <= SW_ONE && sw_b_ff >= SW_MINUS_ONE), "switching value outside [-1, +1]")
   `SMO_ASSERT_NEXT(a_busy_after_accept, req_accept, !req_tready, "ready high right after a transaction was taken")
   `SMO_ASSERT(a_div_done_wait, div_res.done |-> (state_ff == S_DIV_WAIT), "divider finished outside its wait state")
   `SMO_ASSERT_NEXT(a_state_hold, !rsp_load, $stable(prev_ia_ff) && $stable(prev_eb_ff), "observer state moved without a response")

endmodule

@@ dv/tb_sliding_mode_emf_observer_top.sv @@
// ----------------------------------------------------------------------------
// Sliding-mode EMF observer testbench
// Sends measurement transactions under several register settings and checks
// every estimate, field by field, against a fixed-point observer predictor.
// ----------------------------------------------------------------------------
module tb_sliding_mode_emf_observer_top;
   import smo_pkg::*;

   localparam longint WORD_MAX    = (longint'(1) <<< (DATA_W - 1)) - 1;
   localparam longint WORD_MIN    = -WORD_MAX - 1;
   localparam longint Q_ONE       = longint'(1) <<< FRAC_W;
   localparam uword_type UWORD_MAX = '1;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam int TXN_CYCLES   = 70;
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 5000;
   localparam int RANDOM_ITEMS = 150;

   typedef struct {
      word_type current_alpha;
      word_type current_beta;
      word_type voltage_alpha;
      word_type voltage_beta;
      word_type speed;
   } meas_type;

   typedef struct {
      word_type est_ia;
      word_type est_ib;
      word_type est_ea;
      word_type est_eb;
      sw_type   switch_alpha;
      sw_type   switch_beta;
   } estimate_type;

   typedef struct {
      word_type  gain_a;
      word_type  gain_b;
      word_type  gain_c;
      word_type  switch_gain;
      word_type  emf_gain;
      uword_type boundary_layer;
      uword_type sample_period;
   } observer_regs_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_wdata;

   // predictor copy of the registers and the observer state
   observer_regs_type model_regs = '{0, 0, 0, 0, 0, BL_RESET, 0};
   word_type obs_cur_alpha = 0;
   word_type obs_cur_beta  = 0;
   word_type obs_emf_alpha = 0;
   word_type obs_emf_beta  = 0;

   estimate_type pending_estimates[$];
   int  error_count       = 0;
   int  meas_sent         = 0;
   int  estimates_checked = 0;
   int  settings_applied  = 0;
   int  hold_request      = 0;
   int  hold_left         = 0;
   int  stall_left        = 0;
   int  quiet_cycles      = 0;
   bit  idle_on           = 1'b1;

   sliding_mode_emf_observer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------ predictor
   function automatic longint clamp_word(input longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // arithmetic shift floors the exact product
   function automatic longint fx_mul(input longint a, input longint b);
      longint p;
      p = a * b;
      return clamp_word(p >>> FRAC_W);
   endfunction

   function automatic longint switch_value(input longint err, input longint layer);
      longint q;
      longint m;
      if (err > layer) return Q_ONE;
      if (err < -layer) return -Q_ONE;
      if (layer == 0) return 0;
      m = (err < 0) ? -err : err;
      q = (m <<< FRAC_W) / layer;
      return (err < 0) ? -q : q;
   endfunction

   function automatic estimate_type predict_estimate(input meas_type s);
      longint pia, pib, pea, peb, za, zb, bw, ck, cm, tw, nia, nib, nea, neb;
      estimate_type r;
      pia = obs_cur_alpha;
      pib = obs_cur_beta;
      pea = obs_emf_alpha;
      peb = obs_emf_beta;
      za  = switch_value(clamp_word(pia - longint'(s.current_alpha)),
                         model_regs.boundary_layer);
      zb  = switch_value(clamp_word(pib - longint'(s.current_beta)),
                         model_regs.boundary_layer);
      bw  = fx_mul(model_regs.gain_b, s.speed);
      ck  = fx_mul(model_regs.gain_c, model_regs.switch_gain);
      cm  = fx_mul(model_regs.gain_c, model_regs.emf_gain);
      tw  = fx_mul(model_regs.sample_period, s.speed);

      nia = clamp_word(fx_mul(model_regs.gain_a, pia) - fx_mul(bw, pib));
      nia = clamp_word(nia + fx_mul(model_regs.gain_c,
                                    clamp_word(longint'(s.voltage_alpha) - pea)));
      nia = clamp_word(nia - fx_mul(ck, za));

      nib = clamp_word(fx_mul(model_regs.gain_a, pib) + fx_mul(bw, pia));
      nib = clamp_word(nib + fx_mul(model_regs.gain_c,
                                    clamp_word(longint'(s.voltage_beta) - peb)));
      nib = clamp_word(nib - fx_mul(ck, zb));

      nea = clamp_word(pea - fx_mul(tw, peb));
      nea = clamp_word(nea + fx_mul(cm, za));

      neb = clamp_word(peb + fx_mul(tw, pea));
      neb = clamp_word(neb + fx_mul(cm, zb));

      obs_cur_alpha = word_type'(nia);
      obs_cur_beta  = word_type'(nib);
      obs_emf_alpha = word_type'(nea);
      obs_emf_beta  = word_type'(neb);

      r.est_ia       = word_type'(nia);
      r.est_ib       = word_type'(nib);
      r.est_ea       = word_type'(nea);
      r.est_eb       = word_type'(neb);
      r.switch_alpha = sw_type'(za);
      r.switch_beta  = sw_type'(zb);
      return r;
   endfunction

   // ------------------------------------------------------------ generators
   function automatic meas_type make_meas(input longint ia, input longint ib,
                                          input longint va, input longint vb,
                                          input longint w);
      meas_type m;
      m.current_alpha = word_type'(ia);
      m.current_beta  = word_type'(ib);
      m.voltage_alpha = word_type'(va);
      m.voltage_beta  = word_type'(vb);
      m.speed         = word_type'(w);
      return m;
   endfunction

   function automatic observer_regs_type make_regs(input longint ga, input longint gb,
                                                   input longint gc, input longint k,
                                                   input longint m, input longint bl,
                                                   input longint ts);
      observer_regs_type r;
      r.gain_a         = word_type'(ga);
      r.gain_b         = word_type'(gb);
      r.gain_c         = word_type'(gc);
      r.switch_gain    = word_type'(k);
      r.emf_gain       = word_type'(m);
      r.boundary_layer = uword_type'(bl);
      r.sample_period  = uword_type'(ts);
      return r;
   endfunction

   function automatic longint extreme_word();
      case ($urandom_range(0, 4))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return 0;
         3:       return 1;
         default: return -1;
      endcase
   endfunction

   function automatic longint rand_gain();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return extreme_word();
      if (pick < 60) return longint'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
      return longint'($urandom);
   endfunction

   function automatic observer_regs_type rand_regs();
      longint bl;
      longint ts;
      case ($urandom_range(0, 9))
         0:       bl = 0;
         1:       bl = UWORD_MAX;
         2:       bl = 1;
         3, 4, 5: bl = $urandom_range(1, 1 << 20);
         default: bl = $urandom_range(1 << 20, UWORD_MAX);
      endcase
      ts = ($urandom_range(0, 3) == 0) ? longint'($urandom) : $urandom_range(0, Q_ONE);
      return make_regs(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                       bl, ts);
   endfunction

   // half the time, track the current estimate so the error lands near the layer
   function automatic meas_type rand_meas();
      meas_type m;
      int unsigned pick;
      longint span;
      m = make_meas($urandom, $urandom, $urandom, $urandom, $urandom);
      pick = $urandom_range(0, 99);
      span = 2 * longint'(model_regs.boundary_layer) + 16;
      if (span > (longint'(1) <<< 30)) span = longint'(1) <<< 30;
      if (pick < 50) begin
         m.current_alpha = word_type'(clamp_word(longint'(obs_cur_alpha) +
                                     longint'($urandom_range(0, 2 * span)) - span));
         m.current_beta  = word_type'(clamp_word(longint'(obs_cur_beta) +
                                     longint'($urandom_range(0, 2 * span)) - span));
         m.voltage_alpha = word_type'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
         m.voltage_beta  = word_type'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
         m.speed         = word_type'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
      end else if (pick < 65) begin
         m = make_meas(extreme_word(), extreme_word(), extreme_word(), extreme_word(),
                       extreme_word());
      end
      return m;
   endfunction

   // mostly short, a few long
   function automatic int pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 90);
   endfunction

   // ------------------------------------------------------------ driving
   task automatic send_meas(input meas_type s);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {s.speed, s.voltage_beta, s.voltage_alpha, s.current_beta,
                     s.current_alpha};
      do @(posedge clock); while (!req_tready);
      pending_estimates.push_back(predict_estimate(s));
      meas_sent++;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_estimates_done();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // write every register, plus a dropped write to the unmapped index
   task automatic set_config(input observer_regs_type r);
      wait_estimates_done();
      csr_put(REG_GAIN_A, r.gain_a);
      csr_put(REG_GAIN_B, r.gain_b);
      csr_put(REG_GAIN_C, r.gain_c);
      csr_put(REG_SWITCH_GAIN, r.switch_gain);
      csr_put(REG_EMF_GAIN, r.emf_gain);
      csr_put(REG_UNMAPPED, $urandom);
      csr_put(REG_BOUNDARY_LAYER, {1'($urandom_range(0, 1)), r.boundary_layer});
      csr_put(REG_SAMPLE_PERIOD, {1'($urandom_range(0, 1)), r.sample_period});
      csr_we <= 1'b0;
      model_regs = r;
      settings_applied++;
   endtask

   // ------------------------------------------------------------ checking
   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_estimate();
      estimate_type want;
      if (pending_estimates.size() == 0) begin
         $error("estimate transaction with no measurement pending");
         error_count++;
         return;
      end
      want = pending_estimates.pop_front();
      estimates_checked++;
      check_field("est_current_alpha", want.est_ia, word_type'(rsp_tdata[DATA_W-1:0]));
      check_field("est_current_beta", want.est_ib,
                  word_type'(rsp_tdata[DATA_W +: DATA_W]));
      check_field("est_emf_alpha", want.est_ea, word_type'(rsp_tdata[2*DATA_W +: DATA_W]));
      check_field("est_emf_beta", want.est_eb, word_type'(rsp_tdata[3*DATA_W +: DATA_W]));
      check_field("switch_alpha", want.switch_alpha, sw_type'(rsp_tdata[4*DATA_W +: SW_W]));
      check_field("switch_beta", want.switch_beta,
                  sw_type'(rsp_tdata[4*DATA_W+SW_W +: SW_W]));
      check_field("zero fill", 0, rsp_tdata[RSP_W-1:RSP_RAW_W]);
   endtask

   // receiver: check, then choose next cycle's ready
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_estimate();
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no transaction for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------ tests
   // reset registers: zero gains, so only the switching values move
   task automatic test_switch_at_reset();
      send_meas(make_meas(0, 0, 0, 0, 0));
      send_meas(make_meas(-Q_ONE, Q_ONE, WORD_MAX, WORD_MIN, WORD_MAX));
      send_meas(make_meas(-Q_ONE - 1, Q_ONE + 1, WORD_MIN, WORD_MAX, WORD_MIN));
      send_meas(make_meas(-Q_ONE / 2, 12345, 1, -1, 0));
      // error beyond the word range saturates before the compare
      send_meas(make_meas(WORD_MIN, WORD_MAX, -1, 1, -1));
   endtask

   task automatic test_saturation_extremes();
      set_config(make_regs(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX,
                           UWORD_MAX, UWORD_MAX));
      send_meas(make_meas(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
      send_meas(make_meas(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
      send_meas(make_meas(0, 0, WORD_MAX, WORD_MAX, WORD_MIN));
      send_meas(make_meas(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX));
      set_config(make_regs(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 1, 0));
      send_meas(make_meas(1, -1, WORD_MAX, WORD_MIN, WORD_MAX));
      send_meas(make_meas(WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, -1));
      send_meas(make_meas(0, 0, 0, 0, 0));
   endtask

   task automatic test_unity_dynamics();
      longint bl;
      bl = 2 * Q_ONE;
      set_config(make_regs(Q_ONE, Q_ONE / 2, Q_ONE, Q_ONE / 4, Q_ONE / 2, bl, Q_ONE));
      send_meas(make_meas(3 * Q_ONE, -2 * Q_ONE, 5 * Q_ONE, -Q_ONE, 10 * Q_ONE));
      // error exactly on the layer, then just outside it
      send_meas(make_meas(clamp_word(obs_cur_alpha - bl), clamp_word(obs_cur_beta + bl),
                          Q_ONE, Q_ONE, -10 * Q_ONE));
      send_meas(make_meas(clamp_word(obs_cur_alpha - bl - 1),
                          clamp_word(obs_cur_beta + bl + 1), -Q_ONE, 2 * Q_ONE, Q_ONE));
      send_meas(make_meas(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MAX));
      send_meas(make_meas(0, 0, WORD_MIN, WORD_MIN, WORD_MIN));
   endtask

   // zero layer: the sign of the error alone picks the switching value
   task automatic test_zero_boundary_layer();
      set_config(make_regs(Q_ONE, Q_ONE / 8, Q_ONE / 2, Q_ONE, Q_ONE, 0, Q_ONE / 16));
      send_meas(make_meas(obs_cur_alpha, obs_cur_beta, Q_ONE, -Q_ONE, Q_ONE));
      send_meas(make_meas(clamp_word(obs_cur_alpha - 1), clamp_word(obs_cur_beta + 1),
                          -Q_ONE, Q_ONE, 2 * Q_ONE));
      send_meas(make_meas(clamp_word(obs_cur_alpha + 1), clamp_word(obs_cur_beta - 1),
                          0, 0, -Q_ONE));
   endtask

   task automatic test_backpressure();
      set_config(rand_regs());
      // hold the output off while input keeps coming, so the block stalls
      idle_on      = 1'b0;
      hold_request = HOLD_CYCLES;
      repeat (6) send_meas(rand_meas());
      wait_estimates_done();
      idle_on = 1'b1;
      repeat (10) send_meas(rand_meas());
      // pause input until every estimate is back, then carry on
      wait_estimates_done();
      repeat (10) send_meas(rand_meas());
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         set_config(rand_regs());
         idle_on = (phase % 3 != 2);
         repeat (RANDOM_ITEMS) send_meas(rand_meas());
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_switch_at_reset();
      test_saturation_extremes();
      test_unity_dynamics();
      test_zero_boundary_layer();
      test_backpressure();
      test_random_settings();

      wait_estimates_done();
      repeat (2 * TXN_CYCLES) @(posedge clock);

      $display("Summary: %0d measurements under %0d register settings, %0d estimates checked",
               meas_sent, settings_applied, estimates_checked);
      $display("Summary: layer edges, zero layer, saturating products and sums, stalls");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
